// File: rtl/isq_pkg.sv
// Package for the indexed sequence store.
// Holds operation and status codes, sizing constants and the cell command struct.
// Used by isq_cell and indexed_sequence_store_unit.
`default_nettype none

package isq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;

	localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_APPEND   = 3'd0,
		OP_PUSH_HEAD = 3'd1,
		OP_DEL_AT   = 3'd2,
		OP_DEL_HEAD = 3'd3,
		OP_READ     = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell for one accepted item
	typedef struct packed {
		logic              en;
		op_t               op;
		logic              full;
		logic [VAL_W-1:0]  val;
		logic [IDX_W-1:0]  idx;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/isq_cell.sv
// One storage cell of the sequence chain.
// Loads the new value, its left or right neighbor, or holds. Depends on isq_pkg.
`default_nettype none

module isq_cell import isq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int POS   = 0
) (
	input  wire logic                        clk,
	input  wire cell_cmd_t                   cmd,
	input  wire logic [$clog2(DEPTH+1)-1:0]  occ,
	input  wire logic [VAL_W-1:0]            left_val,
	input  wire logic [VAL_W-1:0]            right_val,
	output logic      [VAL_W-1:0]            val
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CW    = (OCC_W > IDX_W) ? OCC_W : IDX_W;

	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] val_nxt;
	logic             at_tail;
	logic             at_or_past_idx;

	assign at_tail        = (occ == OCC_W'(POS));
	assign at_or_past_idx = (CW'(POS) >= CW'(cmd.idx));

	// Cell update; cells at or past the count hold don't-care data
	always_comb begin
		val_nxt = val_q;
		if (cmd.en) begin
			unique case (cmd.op)
				OP_APPEND: begin
					if (!cmd.full && at_tail)
						val_nxt = cmd.val;
				end
				OP_PUSH_HEAD: begin
					if (!cmd.full)
						val_nxt = (POS == 0) ? cmd.val : left_val;
				end
				OP_DEL_AT: begin
					if (at_or_past_idx)
						val_nxt = right_val;
				end
				OP_DEL_HEAD: begin
					val_nxt = right_val;
				end
				default: begin
					val_nxt = val_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

	assign val = val_q;

endmodule

`default_nettype wire

// File: rtl/indexed_sequence_store_unit.sv
// Indexed sequence store: a chain of DEPTH cells that shift together.
// Result: the result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while out_ready is high; the chain shifts in parallel per accepted item.
// Reset: arst_n clears the occupancy and the output valid; cell data and the result outputs are not reset.
// Depends on isq_pkg and isq_cell.
`default_nettype none

module indexed_sequence_store_unit import isq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic [IDX_W-1:0]        index,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [VAL_W-1:0]      read_value,
	output logic [ST_W-1:0]              status,
	output logic [CNT_W-1:0]             count
);

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CW    = (OCC_W > IDX_W) ? OCC_W : IDX_W;
	localparam int RD_N  = (DEPTH < (1 << IDX_W)) ? DEPTH : (1 << IDX_W);
	localparam int RIW   = $clog2(RD_N);

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] occ_nxt;
	logic             out_valid_q;
	logic [VAL_W-1:0] read_value_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	op_t              op_e;
	logic             full;
	logic             idx_ok;
	logic [VAL_W-1:0] rd_nxt;
	status_t          st_nxt;
	cell_cmd_t        cmd;

	logic [VAL_W-1:0] cell_val [DEPTH];
	logic [VAL_W-1:0] rd_tap   [RD_N];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign op_e     = op_t'(op);
	assign full     = (occ_q == OCC_W'(DEPTH));
	assign idx_ok   = (CW'(index) < CW'(occ_q));

	assign cmd.en   = accept;
	assign cmd.op   = op_e;
	assign cmd.full = full;
	assign cmd.val  = value;
	assign cmd.idx  = index;

	// Cell chain; the end cells see their own value past the edge
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;
		if (g == 0) begin : g_first
			assign left_v = cell_val[g];
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_v = cell_val[g];
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end
		isq_cell #(
			.DEPTH (DEPTH),
			.POS   (g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (occ_q),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[g])
		);
	end

	// Read taps: only the positions the index field can reach
	for (genvar r = 0; r < RD_N; r++) begin : g_tap
		assign rd_tap[r] = cell_val[r];
	end

	// Operation decode: count update, read value, status
	always_comb begin
		occ_nxt = occ_q;
		rd_nxt  = '0;
		st_nxt  = ST_OK;
		unique case (op_e)
			OP_APPEND, OP_PUSH_HEAD: begin
				if (full)
					st_nxt = ST_FULL;
				else
					occ_nxt = occ_q + OCC_W'(1);
			end
			OP_DEL_AT: begin
				if (idx_ok)
					occ_nxt = occ_q - OCC_W'(1);
				else
					st_nxt = ST_RANGE;
			end
			OP_DEL_HEAD: begin
				if (occ_q != '0)
					occ_nxt = occ_q - OCC_W'(1);
				else
					st_nxt = ST_RANGE;
			end
			OP_READ: begin
				if (idx_ok) begin
					rd_nxt = rd_tap[index[RIW-1:0]];
				end else begin
					rd_nxt = INT_MIN;
					st_nxt = ST_RANGE;
				end
			end
			default: begin
				st_nxt = ST_RANGE;
			end
		endcase
	end

	// Count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				occ_q <= occ_nxt;
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= rd_nxt;
			status_q     <= st_nxt;
			count_q      <= CNT_W'(occ_nxt);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for indexed_sequence_store_unit: directed and random operation items,
// checked one result item at a time against a predictor of the stored sequence.
// Depends on rtl/isq_pkg.sv and the RTL of the unit.
`default_nettype none

module tb;
	import isq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEQ_DEPTH = DEPTH_DEF;
	localparam int OP_UNUSED_FIRST = 5;
	localparam int OP_UNUSED_LAST = (1 << OP_W) - 1;
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam int STALL_MAX = 4;
	localparam int HOLD_CYCLES = 60;
	localparam int IDLE_LIMIT = 500;
	localparam int DRAIN_CYCLES = 4;

	typedef struct {
		logic signed [VAL_W-1:0] rd;
		status_t                 st;
		logic [CNT_W-1:0]        cnt;
	} seq_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         op = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic [IDX_W-1:0]        index = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]         status;
	logic [CNT_W-1:0]        count;

	// Predicted contents of the store
	logic signed [VAL_W-1:0] seq_cells [SEQ_DEPTH];
	int                      seq_len = 0;
	seq_result_t             pending_results [$];

	// Flow control for sender and receiver, and the grow or shrink bias of random items
	bit steady_flow = 1'b0;
	int hold_len = 0;
	bit growing = 1'b1;

	int n_items = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_full = 0;
	int n_range = 0;
	int n_reads = 0;
	int idle_cycles = 0;

	indexed_sequence_store_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.value      (value),
		.index      (index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.status     (status),
		.count      (count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one operation to the predicted sequence and return its result item
	function automatic seq_result_t apply_to_sequence(input logic [OP_W-1:0] code,
			input logic signed [VAL_W-1:0] v, input logic [IDX_W-1:0] pos);
		seq_result_t r;
		int start;
		r.rd = '0;
		r.st = ST_OK;
		case (code)
			OP_APPEND: begin
				if (seq_len >= SEQ_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					seq_cells[seq_len] = v;
					seq_len++;
				end
			end
			OP_PUSH_HEAD: begin
				if (seq_len >= SEQ_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					for (int k = seq_len; k > 0; k--)
						seq_cells[k] = seq_cells[k-1];
					seq_cells[0] = v;
					seq_len++;
				end
			end
			OP_DEL_AT, OP_DEL_HEAD: begin
				start = (code == OP_DEL_HEAD) ? 0 : int'(pos);
				if (start < seq_len) begin
					for (int k = start; k + 1 < seq_len; k++)
						seq_cells[k] = seq_cells[k+1];
					seq_len--;
				end else begin
					r.st = ST_RANGE;
				end
			end
			OP_READ: begin
				if (int'(pos) < seq_len) begin
					r.rd = seq_cells[pos];
					n_reads++;
				end else begin
					r.rd = INT_MIN;
					r.st = ST_RANGE;
				end
			end
			default: r.st = ST_RANGE;
		endcase
		r.cnt = seq_len[CNT_W-1:0];
		return r;
	endfunction

	// Predict on accepted input items, check accepted result items
	always @(posedge clk) begin
		if (in_valid && in_ready)
			pending_results.push_back(apply_to_sequence(op, value, index));
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: read_value=%0d status=%0d count=%0d",
					read_value, status, count);
				n_errors++;
			end else begin
				seq_result_t exp_r;
				exp_r = pending_results.pop_front();
				if (read_value !== exp_r.rd) begin
					$error("read_value: expected %0d, got %0d", exp_r.rd, read_value);
					n_errors++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, got %0d", exp_r.st, status);
					n_errors++;
				end
				if (count !== exp_r.cnt) begin
					$error("count: expected %0d, got %0d", exp_r.cnt, count);
					n_errors++;
				end
				if (exp_r.st == ST_FULL)
					n_full++;
				if (exp_r.st == ST_RANGE)
					n_range++;
				n_checked++;
			end
		end
	end

	// Watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result receiver: random stalls per item, plus a long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = steady_flow ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one item after a random gap (no gap in steady flow) and wait until it is taken;
	// entered and left just after a rising edge
	task automatic send_item(input logic [OP_W-1:0] code, input logic signed [VAL_W-1:0] v,
			input logic [IDX_W-1:0] pos);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		value <= v;
		index <= pos;
		do @(posedge clk); while (!in_ready);
		n_items++;
	endtask

	// Random item, biased to grow or shrink the sequence so both ends are reached
	task automatic send_random_item();
		int pick;
		logic [OP_W-1:0] code;
		logic signed [VAL_W-1:0] v;
		logic [IDX_W-1:0] pos;
		if (seq_len >= SEQ_DEPTH)
			growing = 1'b0;
		else if (seq_len == 0)
			growing = 1'b1;
		else if ($urandom_range(0, 24) == 0)
			growing = !growing;
		pick = $urandom_range(0, 99);
		if (pick < 3)
			code = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		else if (pick < 30)
			code = OP_READ;
		else if (pick < 42)
			code = growing ? ($urandom_range(0, 1) ? OP_DEL_AT : OP_DEL_HEAD)
				: ($urandom_range(0, 1) ? OP_APPEND : OP_PUSH_HEAD);
		else
			code = growing ? ($urandom_range(0, 1) ? OP_APPEND : OP_PUSH_HEAD)
				: ($urandom_range(0, 2) != 0 ? OP_DEL_AT : OP_DEL_HEAD);
		case ($urandom_range(0, 19))
			0: v = INT_MIN;
			1: v = VAL_MAX;
			2: v = '0;
			3: v = '1;
			default: v = $urandom();
		endcase
		// mostly positions that exist, sometimes anywhere
		if (seq_len > 0 && $urandom_range(0, 7) != 0)
			pos = IDX_W'($urandom_range(0, seq_len - 1));
		else
			pos = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		send_item(code, v, pos);
	endtask

	// Deletes and reads on an empty store, and the unused op codes
	task automatic test_empty_store();
		send_item(OP_DEL_HEAD, '0, '0);
		send_item(OP_DEL_AT, '0, '1);
		send_item(OP_READ, '0, '0);
		for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
			send_item(OP_W'(c), VAL_MAX, '1);
	endtask

	// Fill from both ends, refuse when full, then drop the last element and read past the end
	task automatic test_fill_to_full();
		logic signed [VAL_W-1:0] v;
		for (int k = 0; k < SEQ_DEPTH; k++) begin
			case (k)
				0: v = INT_MIN;
				1: v = VAL_MAX;
				2: v = '0;
				3: v = '1;
				default: v = $urandom();
			endcase
			send_item(k[0] ? OP_PUSH_HEAD : OP_APPEND, v, '0);
		end
		send_item(OP_APPEND, $urandom(), '0);
		send_item(OP_PUSH_HEAD, $urandom(), '0);
		send_item(OP_DEL_AT, '0, IDX_W'(SEQ_DEPTH - 1));
		send_item(OP_READ, '0, IDX_W'(SEQ_DEPTH - 1));
	endtask

	// Random mix; the tail of every hundred items runs with no gaps at all
	task automatic test_random_mix(input int n);
		for (int i = 0; i < n; i++) begin
			steady_flow = (i % 100) >= 80;
			send_random_item();
		end
		steady_flow = 1'b0;
	endtask

	// Receiver holds off while the sender keeps offering, so the unit stalls its input
	task automatic test_output_stall(input int n);
		steady_flow = 1'b1;
		hold_len = HOLD_CYCLES;
		for (int i = 0; i < n; i++)
			send_random_item();
		steady_flow = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_store();
		test_fill_to_full();
		test_random_mix(250);
		test_output_stall(40);
		test_random_mix(260);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items, checked %0d results: %0d in-range reads,", n_items,
			n_checked, n_reads);
		$display("%0d full refusals, %0d range or empty statuses.", n_full, n_range);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
rtl/isq_pkg.sv
rtl/isq_cell.sv
rtl/indexed_sequence_store_unit.sv
sim/tb.sv
